// File: src/sqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared types, constant tables and elaboration-time helpers for the
// square-to-disk mapping pipeline.
// ----------------------------------------------------------------------------
package sqd_pkg;

   typedef enum logic [1:0] {
      QUAD_EAST  = 2'd0,
      QUAD_NORTH = 2'd1,
      QUAD_WEST  = 2'd2,
      QUAD_SOUTH = 2'd3
   } quadrant_type;

   localparam int ATAN_ENTRIES = 30;

   // pi/4 in Q32, rounded
   localparam logic [31:0] PI_QUARTER_Q32 = 32'd3373259426;

   // atan(2^-i) in Q32, rounded
   localparam logic [31:0] ATAN_Q32 [ATAN_ENTRIES] = '{
      32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
      32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
      32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
      32'd1048576,    32'd524288,     32'd262144,     32'd131072,
      32'd65536,      32'd32768,      32'd16384,      32'd8192,
      32'd4096,       32'd2048,       32'd1024,       32'd512,
      32'd256,        32'd128,        32'd64,         32'd32,
      32'd16,         32'd8
   };

   function automatic logic [63:0] isqrt64(input logic [63:0] n_arg);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bitv;
      n    = n_arg;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bitv > n) begin
            bitv = bitv >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 64'd0) begin
            if (n >= res + bitv) begin
               n   = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // cordic gain compensation in Q32, evaluated at elaboration only
   function automatic logic [31:0] cordic_gain_q32(input int steps);
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] num;
      logic [64:0] rem;
      logic [63:0] quo;
      p = 64'd1 << 32;
      for (int i = 0; i < ATAN_ENTRIES; i++) begin
         if (i < steps) begin
            p = p + (p >> (2 * i));
         end
      end
      s = isqrt64(p << 30);
      if (s == 64'd0) begin
         return 32'd0;
      end
      num = (64'd1 << 63) + (s >> 1);
      rem = '0;
      quo = '0;
      // restoring long division, one quotient bit per pass
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, s}) begin
            rem    = rem - {1'b0, s};
            quo[i] = 1'b1;
         end
      end
      return quo[31:0];
   endfunction

endpackage
`default_nettype wire

// File: src/sqd_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqd channel interfaces
// Valid/ready channels for square samples in and disk points out.
// ----------------------------------------------------------------------------
interface sqd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_u;
   logic [15:0] sample_v;

   modport source (output valid, output sample_u, output sample_v, input ready);
   modport sink   (input valid, input sample_u, input sample_v, output ready);
endinterface

interface sqd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] disk_x;
   logic signed [17:0] disk_y;

   modport source (output valid, output disk_x, output disk_y, input ready);
   modport sink   (input valid, input disk_x, input disk_y, output ready);
endinterface
`default_nettype wire

// File: src/sqd_region.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_region
// Maps the sample to [-1,1), picks the quadrant region and registers the
// quotient operands in magnitude form.
// ----------------------------------------------------------------------------
module sqd_region #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [15:0]              sample_u,
   input  wire logic [15:0]              sample_v,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [FRAC_BITS:0]            num_mag,
   output logic [FRAC_BITS:0]            den_mag,
   output logic                          q_neg,
   output sqd_pkg::quadrant_type         quad
);

   localparam logic signed [FRAC_BITS+1:0] ONE = {2'b01, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS+16:0]        u_wide;
   logic [FRAC_BITS+16:0]        v_wide;
   logic signed [FRAC_BITS+1:0]  a_val;
   logic signed [FRAC_BITS+1:0]  b_val;
   logic signed [FRAC_BITS+1:0]  b_neg;
   logic signed [FRAC_BITS+1:0]  num_val;
   logic signed [FRAC_BITS+1:0]  den_val;
   logic signed [FRAC_BITS+1:0]  num_abs;
   logic signed [FRAC_BITS+1:0]  den_abs;
   logic                         neg_swap;
   sqd_pkg::quadrant_type        quad_in;

   logic                         vld_ff;
   logic [FRAC_BITS:0]           num_ff;
   logic [FRAC_BITS:0]           den_ff;
   logic                         neg_ff;
   sqd_pkg::quadrant_type        quad_ff;

   always_comb begin
      u_wide  = {sample_u, {(FRAC_BITS+1){1'b0}}};
      v_wide  = {sample_v, {(FRAC_BITS+1){1'b0}}};
      a_val   = $signed({1'b0, u_wide[FRAC_BITS+16:16]}) - ONE;
      b_val   = $signed({1'b0, v_wide[FRAC_BITS+16:16]}) - ONE;
      b_neg   = -b_val;
      if (a_val > b_neg) begin
         if (a_val > b_val) begin
            quad_in = sqd_pkg::QUAD_EAST;  num_val = b_val; den_val = a_val; neg_swap = 1'b0;
         end else begin
            quad_in = sqd_pkg::QUAD_NORTH; num_val = a_val; den_val = b_val; neg_swap = 1'b1;
         end
      end else begin
         if (a_val < b_val) begin
            quad_in = sqd_pkg::QUAD_WEST;  num_val = b_val; den_val = a_val; neg_swap = 1'b0;
         end else begin
            quad_in = sqd_pkg::QUAD_SOUTH; num_val = a_val; den_val = b_val; neg_swap = 1'b1;
         end
      end
      num_abs = num_val[FRAC_BITS+1] ? -num_val : num_val;
      den_abs = den_val[FRAC_BITS+1] ? -den_val : den_val;
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         num_ff  <= num_abs[FRAC_BITS:0];
         den_ff  <= den_abs[FRAC_BITS:0];
         neg_ff  <= (num_val[FRAC_BITS+1] ^ den_val[FRAC_BITS+1]) ^ neg_swap;
         quad_ff <= quad_in;
      end
   end

   assign out_valid = vld_ff;
   assign num_mag   = num_ff;
   assign den_mag   = den_ff;
   assign q_neg     = neg_ff;
   assign quad      = quad_ff;

endmodule
`default_nettype wire

// File: src/sqd_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_divider
// Pipelined restoring divider, one quotient bit per stage, giving
// num * 2^FRAC_BITS / den for num <= den; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module sqd_divider #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [FRAC_BITS:0]       num_mag,
   input  wire logic [FRAC_BITS:0]       den_mag,
   input  wire logic                     in_neg,
   input  wire sqd_pkg::quadrant_type    in_quad,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [FRAC_BITS:0]            q_mag,
   output logic [FRAC_BITS:0]            radius,
   output logic                          out_neg,
   output sqd_pkg::quadrant_type         out_quad
);

   localparam int NST = FRAC_BITS + 1;

   logic [NST-1:0]          vld_ff;
   logic [NST:0]            rdy;
   logic [FRAC_BITS+1:0]    rem_ff  [NST];
   logic [FRAC_BITS:0]      den_ff  [NST];
   logic [FRAC_BITS:0]      quo_ff  [NST];
   logic                    neg_ff  [NST];
   sqd_pkg::quadrant_type   quad_ff [NST];

   assign rdy[NST] = out_ready;
   assign in_ready = rdy[0];

   for (genvar j = 0; j < NST; j++) begin : g_stage
      logic                  vld_src;
      logic [FRAC_BITS+1:0]  rem_src;
      logic [FRAC_BITS:0]    den_src;
      logic [FRAC_BITS:0]    quo_src;
      logic                  neg_src;
      sqd_pkg::quadrant_type quad_src;
      logic                  take;
      logic [FRAC_BITS+1:0]  diff;
      logic [FRAC_BITS+1:0]  rem_in;
      logic [FRAC_BITS:0]    quo_in;

      if (j == 0) begin : g_head
         assign vld_src  = in_valid;
         assign rem_src  = {1'b0, num_mag};
         assign den_src  = den_mag;
         assign quo_src  = '0;
         assign neg_src  = in_neg;
         assign quad_src = in_quad;
      end else begin : g_body
         assign vld_src  = vld_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign den_src  = den_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign neg_src  = neg_ff[j-1];
         assign quad_src = quad_ff[j-1];
      end

      assign rdy[j] = !vld_ff[j] || rdy[j+1];

      always_comb begin
         take   = rem_src >= {1'b0, den_src};
         diff   = take ? rem_src - {1'b0, den_src} : rem_src;
         rem_in = {diff[FRAC_BITS:0], 1'b0};
         quo_in = {quo_src[FRAC_BITS-1:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            vld_ff[j] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j]) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_src;
            quo_ff[j]  <= quo_in;
            neg_ff[j]  <= neg_src;
            quad_ff[j] <= quad_src;
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign q_mag     = (den_ff[NST-1] == '0) ? '0 : quo_ff[NST-1];
   assign radius    = den_ff[NST-1];
   assign out_neg   = neg_ff[NST-1];
   assign out_quad  = quad_ff[NST-1];

endmodule
`default_nettype wire

// File: src/sqd_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_scale
// Two stages: multiply the quotient by pi/4 and the radius by the cordic
// gain compensation, then round both products back to Q(FRAC_BITS).
// ----------------------------------------------------------------------------
module sqd_scale #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [FRAC_BITS:0]         q_mag,
   input  wire logic [FRAC_BITS:0]         radius,
   input  wire logic                       in_neg,
   input  wire sqd_pkg::quadrant_type      in_quad,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic signed [FRAC_BITS+2:0]     theta,
   output logic signed [FRAC_BITS+2:0]     x_start,
   output sqd_pkg::quadrant_type           out_quad
);

   localparam int          PW   = FRAC_BITS + 33;
   localparam logic [31:0] GAIN = sqd_pkg::cordic_gain_q32(CORDIC_STEPS);
   localparam logic [PW:0] HALF = (PW+1)'(1) << 31;

   logic [1:0]              vld_ff;
   logic [2:0]              rdy;
   logic [PW-1:0]           pt_ff;
   logic [PW-1:0]           pg_ff;
   logic                    neg_ff;
   sqd_pkg::quadrant_type   quad_a_ff;
   logic signed [FRAC_BITS+2:0] theta_ff;
   logic signed [FRAC_BITS+2:0] x_ff;
   sqd_pkg::quadrant_type   quad_b_ff;

   logic [PW:0]             pt_rnd;
   logic [PW:0]             pg_rnd;
   logic [FRAC_BITS+2:0]    tm;
   logic [FRAC_BITS+2:0]    theta_in;

   assign rdy[2]   = out_ready;
   assign rdy[1]   = !vld_ff[1] || rdy[2];
   assign rdy[0]   = !vld_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_comb begin
      pt_rnd   = {1'b0, pt_ff} + HALF;
      pg_rnd   = {1'b0, pg_ff} + HALF;
      tm       = {2'b00, pt_rnd[FRAC_BITS+32:32]};
      theta_in = neg_ff ? -tm : tm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= in_valid;
         end
         if (rdy[1]) begin
            vld_ff[1] <= vld_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pt_ff     <= PW'(q_mag) * PW'(sqd_pkg::PI_QUARTER_Q32);
         pg_ff     <= PW'(radius) * PW'(GAIN);
         neg_ff    <= in_neg;
         quad_a_ff <= in_quad;
      end
      if (rdy[1]) begin
         theta_ff  <= $signed(theta_in);
         x_ff      <= $signed({2'b00, pg_rnd[FRAC_BITS+32:32]});
         quad_b_ff <= quad_a_ff;
      end
   end

   assign out_valid = vld_ff[1];
   assign theta     = theta_ff;
   assign x_start   = x_ff;
   assign out_quad  = quad_b_ff;

endmodule
`default_nettype wire

// File: src/sqd_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_cordic
// Unrolled rotation-mode cordic, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module sqd_cordic #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic signed [FRAC_BITS+2:0] theta,
   input  wire logic signed [FRAC_BITS+2:0] x_start,
   input  wire sqd_pkg::quadrant_type      in_quad,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic signed [FRAC_BITS+2:0]     x_out,
   output logic signed [FRAC_BITS+2:0]     y_out,
   output sqd_pkg::quadrant_type           out_quad
);

   localparam int W = FRAC_BITS + 3;

   logic [CORDIC_STEPS-1:0]  vld_ff;
   logic [CORDIC_STEPS:0]    rdy;
   logic signed [W-1:0]      x_ff    [CORDIC_STEPS];
   logic signed [W-1:0]      y_ff    [CORDIC_STEPS];
   logic signed [W-1:0]      z_ff    [CORDIC_STEPS];
   sqd_pkg::quadrant_type    quad_ff [CORDIC_STEPS];

   assign rdy[CORDIC_STEPS] = out_ready;
   assign in_ready          = rdy[0];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic [32:0] TR =
         (33'(sqd_pkg::ATAN_Q32[i]) + (33'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
      localparam logic signed [W-1:0] ANG = $signed(TR[W-1:0]);

      logic                  vld_src;
      logic signed [W-1:0]   x_src;
      logic signed [W-1:0]   y_src;
      logic signed [W-1:0]   z_src;
      sqd_pkg::quadrant_type quad_src;
      logic signed [W-1:0]   dx;
      logic signed [W-1:0]   dy;
      logic signed [W-1:0]   x_in;
      logic signed [W-1:0]   y_in;
      logic signed [W-1:0]   z_in;

      if (i == 0) begin : g_head
         assign vld_src  = in_valid;
         assign x_src    = x_start;
         assign y_src    = '0;
         assign z_src    = theta;
         assign quad_src = in_quad;
      end else begin : g_body
         assign vld_src  = vld_ff[i-1];
         assign x_src    = x_ff[i-1];
         assign y_src    = y_ff[i-1];
         assign z_src    = z_ff[i-1];
         assign quad_src = quad_ff[i-1];
      end

      assign rdy[i] = !vld_ff[i] || rdy[i+1];

      always_comb begin
         dx = y_src >>> i;
         dy = x_src >>> i;
         if (!z_src[W-1]) begin
            x_in = x_src - dx;
            y_in = y_src + dy;
            z_in = z_src - ANG;
         end else begin
            x_in = x_src + dx;
            y_in = y_src - dy;
            z_in = z_src + ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i]) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            quad_ff[i] <= quad_src;
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS-1];
   assign x_out     = x_ff[CORDIC_STEPS-1];
   assign y_out     = y_ff[CORDIC_STEPS-1];
   assign out_quad  = quad_ff[CORDIC_STEPS-1];

endmodule
`default_nettype wire

// File: src/square_to_concentric_disk_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_to_concentric_disk_unit
// Concentric mapping of unit-square samples onto the unit disk.
// ----------------------------------------------------------------------------
// Samples (sample_u, sample_v, unsigned Q0.16) arrive on the req channel and
// disk points (disk_x, disk_y, signed, value/65536, clamped to +-1.0) leave
// on the rsp channel, one point per sample, in order.
// From the req transfer to the rsp valid a sample passes one region stage,
// FRAC_BITS+1 divider stages, two multiply/round stages, CORDIC_STEPS cordic
// stages and the output register.
// Throughput is one sample per cycle while rsp ready is high; every stage is
// a register with its own valid bit, so empty stages keep filling while the
// output waits.
// When the receiver holds rsp ready low, the pipeline fills up and req ready
// drops once no stage is free; nothing is dropped or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module square_to_concentric_disk_unit #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sqd_req_if.sink    req_port,
   sqd_rsp_if.source  rsp_port
);

   localparam int W   = FRAC_BITS + 3;
   localparam int MW  = FRAC_BITS + 20;
   localparam int SH  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic [MW-1:0] RND = (FRAC_BITS > 16) ? (MW'(1) << (SH - 1)) : '0;
   localparam logic [MW-1:0] SAT = MW'(65536);

   logic                  rg_valid, rg_ready;
   logic [FRAC_BITS:0]    rg_num, rg_den;
   logic                  rg_neg;
   sqd_pkg::quadrant_type rg_quad;

   logic                  dv_valid, dv_ready;
   logic [FRAC_BITS:0]    dv_q, dv_r;
   logic                  dv_neg;
   sqd_pkg::quadrant_type dv_quad;

   logic                  sc_valid, sc_ready;
   logic signed [W-1:0]   sc_theta, sc_x;
   sqd_pkg::quadrant_type sc_quad;

   logic                  cd_valid, cd_ready;
   logic signed [W-1:0]   cd_x, cd_y;
   sqd_pkg::quadrant_type cd_quad;

   logic                  out_vld_ff;
   logic signed [17:0]    disk_x_ff, disk_y_ff;
   logic signed [W-1:0]   ox, oy;
   logic signed [17:0]    disk_x_in, disk_y_in;

   function automatic logic signed [17:0] to_q16(input logic signed [W-1:0] val);
      logic [W-1:0]  mag;
      logic [MW-1:0] m;
      logic [17:0]   m18;
      mag = val[W-1] ? -val : val;
      m   = MW'(mag);
      m   = ((m + RND) >> SH) << SHL;
      if (m > SAT) begin
         m = SAT;
      end
      m18 = m[17:0];
      return val[W-1] ? $signed(-m18) : $signed(m18);
   endfunction

   sqd_region #(.FRAC_BITS(FRAC_BITS)) u_region (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .sample_u  (req_port.sample_u),
      .sample_v  (req_port.sample_v),
      .out_valid (rg_valid),
      .out_ready (rg_ready),
      .num_mag   (rg_num),
      .den_mag   (rg_den),
      .q_neg     (rg_neg),
      .quad      (rg_quad)
   );

   sqd_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rg_valid),
      .in_ready  (rg_ready),
      .num_mag   (rg_num),
      .den_mag   (rg_den),
      .in_neg    (rg_neg),
      .in_quad   (rg_quad),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .q_mag     (dv_q),
      .radius    (dv_r),
      .out_neg   (dv_neg),
      .out_quad  (dv_quad)
   );

   sqd_scale #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .q_mag     (dv_q),
      .radius    (dv_r),
      .in_neg    (dv_neg),
      .in_quad   (dv_quad),
      .out_valid (sc_valid),
      .out_ready (sc_ready),
      .theta     (sc_theta),
      .x_start   (sc_x),
      .out_quad  (sc_quad)
   );

   sqd_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sc_valid),
      .in_ready  (sc_ready),
      .theta     (sc_theta),
      .x_start   (sc_x),
      .in_quad   (sc_quad),
      .out_valid (cd_valid),
      .out_ready (cd_ready),
      .x_out     (cd_x),
      .y_out     (cd_y),
      .out_quad  (cd_quad)
   );

   // quarter turns are exact swaps and negations
   always_comb begin
      unique case (cd_quad)
         sqd_pkg::QUAD_EAST:  begin ox = cd_x;  oy = cd_y;  end
         sqd_pkg::QUAD_NORTH: begin ox = -cd_y; oy = cd_x;  end
         sqd_pkg::QUAD_WEST:  begin ox = -cd_x; oy = -cd_y; end
         sqd_pkg::QUAD_SOUTH: begin ox = cd_y;  oy = -cd_x; end
         default:             begin ox = cd_x;  oy = cd_y;  end
      endcase
      disk_x_in = to_q16(ox);
      disk_y_in = to_q16(oy);
   end

   assign cd_ready = !out_vld_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cd_ready) begin
         out_vld_ff <= cd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cd_ready) begin
         disk_x_ff <= disk_x_in;
         disk_y_ff <= disk_y_in;
      end
   end

   assign rsp_port.valid  = out_vld_ff;
   assign rsp_port.disk_x = disk_x_ff;
   assign rsp_port.disk_y = disk_y_ff;

endmodule
`default_nettype wire

// File: tb/sqd_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd testbench channel note
// The channel interfaces come from the design sources; this file only holds
// the sample record used by the checker queue.
// ----------------------------------------------------------------------------
package sqd_tb_pkg;
   typedef struct packed {
      logic signed [17:0] disk_x;
      logic signed [17:0] disk_y;
   } disk_point_type;
endpackage

// File: tb/square_to_concentric_disk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_to_concentric_disk_checker
// Watches both channels, computes the expected disk point for every accepted
// sample and compares each returned point against the oldest expectation.
// ----------------------------------------------------------------------------
module square_to_concentric_disk_checker (
   input  logic        clock,
   input  logic        reset,
   sqd_req_if          req_port,
   sqd_rsp_if          rsp_port,
   output int          fail_count,
   output int          pending_count,
   output int          point_count
);
   localparam int FB = 16;
   localparam int STEPS = 16;

   sqd_tb_pkg::disk_point_type pending_points[$];

   function automatic longint floor_sh(longint val, int s);
      return val >>> s;
   endfunction

   function automatic longint to_q16(longint val);
      longint m;
      m = (val < 0) ? -val : val;
      if (m > 65536) begin
         m = 65536;
      end
      return (val < 0) ? -m : m;
   endfunction

   function automatic sqd_tb_pkg::disk_point_type map_to_disk(logic [15:0] su,
                                                             logic [15:0] sv);
      longint one, a, b, r, num, den, q, theta, x, y, dx, dy, t, ox, oy;
      longint unsigned qm, gain, th_m, p, s;
      sqd_pkg::quadrant_type quad;
      logic negq, neg;
      sqd_tb_pkg::disk_point_type pt;
      one = 64'sd1 <<< FB;
      a = longint'(({48'd0, su} << (FB + 1)) >> 16) - one;
      b = longint'(({48'd0, sv} << (FB + 1)) >> 16) - one;
      if (a > -b) begin
         if (a > b) begin
            r = a; quad = sqd_pkg::QUAD_EAST; num = b; den = a; negq = 1'b0;
         end else begin
            r = b; quad = sqd_pkg::QUAD_NORTH; num = a; den = b; negq = 1'b1;
         end
      end else begin
         if (a < b) begin
            r = -a; quad = sqd_pkg::QUAD_WEST; num = b; den = a; negq = 1'b0;
         end else begin
            r = -b; quad = sqd_pkg::QUAD_SOUTH; num = a; den = b; negq = 1'b1;
         end
      end
      q = 0;
      if (den != 0) begin
         qm = ((num < 0 ? -num : num) << FB) / (den < 0 ? -den : den);
         neg = ((num < 0) != (den < 0)) != negq;
         q = (neg && qm != 0) ? -longint'(qm) : longint'(qm);
      end
      th_m = ((q < 0 ? -q : q) * sqd_pkg::PI_QUARTER_Q32 + (64'd1 << 31)) >> 32;
      theta = (q < 0) ? -longint'(th_m) : longint'(th_m);
      // gain compensation, same recipe as the q32 product and root
      p = 64'd1 << 32;
      for (int i = 0; i < STEPS; i++) begin
         p = p + (p >> (2 * i));
      end
      s = 0;
      begin
         longint unsigned n, bv;
         n = p << 30;
         bv = 64'd1 << 62;
         while (bv > n) bv = bv >> 2;
         while (bv != 0) begin
            if (n >= s + bv) begin
               n = n - (s + bv);
               s = (s >> 1) + bv;
            end else begin
               s = s >> 1;
            end
            bv = bv >> 2;
         end
      end
      gain = ((64'd1 << 63) + s / 2) / s;
      x = longint'((longint'(r) * gain + (64'd1 << 31)) >> 32);
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = floor_sh(y, i);
         dy = floor_sh(x, i);
         t = longint'((sqd_pkg::ATAN_Q32[i] + (64'd1 << (31 - FB))) >> (32 - FB));
         if (theta >= 0) begin
            x -= dx; y += dy; theta -= t;
         end else begin
            x += dx; y -= dy; theta += t;
         end
      end
      case (quad)
         sqd_pkg::QUAD_EAST:  begin ox = x;  oy = y;  end
         sqd_pkg::QUAD_NORTH: begin ox = -y; oy = x;  end
         sqd_pkg::QUAD_WEST:  begin ox = -x; oy = -y; end
         default:             begin ox = y;  oy = -x; end
      endcase
      pt.disk_x = 18'(to_q16(ox));
      pt.disk_y = 18'(to_q16(oy));
      return pt;
   endfunction

   always @(posedge clock) begin
      sqd_tb_pkg::disk_point_type want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         point_count <= 0;
         pending_points.delete();
         pending_count <= 0;
      end else begin
         if (req_port.valid && req_port.ready) begin
            pending_points.push_back(map_to_disk(req_port.sample_u, req_port.sample_v));
         end
         if (rsp_port.valid && rsp_port.ready) begin
            point_count <= point_count + 1;
            if (pending_points.size() == 0) begin
               $error("disk point with no sample outstanding");
               errs++;
            end else begin
               want = pending_points.pop_front();
               if (rsp_port.disk_x !== want.disk_x) begin
                  $error("disk_x expected %0d actual %0d", want.disk_x, rsp_port.disk_x);
                  errs++;
               end
               if (rsp_port.disk_y !== want.disk_y) begin
                  $error("disk_y expected %0d actual %0d", want.disk_y, rsp_port.disk_y);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= pending_points.size();
      end
   end
endmodule

// File: tb/square_to_concentric_disk_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_to_concentric_disk_unit_tb
// Drives corner, axis and diagonal samples and then random samples through
// the disk mapping unit with random gaps and output stalls.
// ----------------------------------------------------------------------------
module square_to_concentric_disk_unit_tb;
   localparam int RANDOM_SAMPLES = 1400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, point_count;
   int   sent_count = 0;
   int   idle_cycles = 0;
   logic stim_done = 1'b0;
   logic long_hold = 1'b0;

   sqd_req_if req_port ();
   sqd_rsp_if rsp_port ();

   square_to_concentric_disk_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port.sink),
      .rsp_port (rsp_port.source)
   );

   square_to_concentric_disk_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_port      (req_port),
      .rsp_port      (rsp_port),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .point_count   (point_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
   endfunction

   task automatic send_sample(logic [15:0] su, logic [15:0] sv);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         req_port.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_port.valid    <= 1'b1;
      req_port.sample_u <= su;
      req_port.sample_v <= sv;
      @(posedge clock);
      while (!req_port.ready) @(posedge clock);
      sent_count++;
   endtask

   // directed corners, axes, diagonals and the center
   logic [15:0] edge_vals [7] = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000,
                                  16'h8001, 16'hfffe, 16'hffff};

   initial begin
      logic [15:0] su, sv;
      req_port.valid    <= 1'b0;
      req_port.sample_u <= '0;
      req_port.sample_v <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 5; j++) begin
            send_sample(edge_vals[i == 4 ? 6 : i], edge_vals[j == 4 ? 6 : j]);
         end
      end
      send_sample(16'h4000, 16'hc000);
      send_sample(16'h8001, 16'h7fff);
      for (int n = 0; n < RANDOM_SAMPLES; n++) begin
         case ($urandom_range(0, 5))
            0: begin su = $urandom; sv = su; end
            1: begin su = $urandom; sv = ~su; end
            2: begin su = edge_vals[$urandom_range(0, 6)]; sv = $urandom; end
            3: begin su = $urandom; sv = edge_vals[$urandom_range(0, 6)]; end
            default: begin su = $urandom; sv = $urandom; end
         endcase
         if (n == 400) long_hold <= 1'b1;
         send_sample(su, sv);
      end
      req_port.valid <= 1'b0;
      stim_done <= 1'b1;
   end

   // receiver: random stalls plus one long hold-off while input keeps coming
   initial begin
      int stall;
      rsp_port.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_port.ready <= 1'b0;
            repeat (150) @(posedge clock);
            long_hold <= 1'b0;
            rsp_port.ready <= 1'b1;
         end else if ($urandom_range(0, 5) == 0 && rsp_port.ready) begin
            stall = gap_len();
            rsp_port.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_port.ready <= 1'b1;
         end else begin
            rsp_port.ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_port.valid && req_port.ready) || (rsp_port.valid && rsp_port.ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d points outstanding", pending_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("mapped %0d samples incl. corners, axes, diagonals and center", sent_count);
      $display("%0d disk points checked, %0d mismatches", point_count, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
